// File: sv/sst_pkg.sv
`timescale 1ns / 1ps

package sst_pkg;

    localparam int VALUE_W     = 16;
    localparam int OP_W        = 2;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 11;
    localparam int IN_DATA_W   = 24;
    localparam int OUT_DATA_W  = 16;
    localparam int GROUP_W     = 32;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_QUERY  = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 2'd0,
        ST_FULL    = 2'd1,
        ST_MISSING = 2'd2
    } status_t;

    // per-cycle command broadcast along the cell row
    typedef struct packed {
        logic cmp;
        logic ins;
        logic del;
    } cell_ctrl_t;

endpackage

// File: sv/sst_cell.sv
`timescale 1ns / 1ps

module sst_cell import sst_pkg::*; #(
    parameter int IDX    = 0,
    parameter int KEY_W  = 16,
    parameter int CNT_W  = 11
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  cell_ctrl_t       ctrl,
    input  logic [KEY_W-1:0] key,
    input  logic [CNT_W-1:0] count,
    input  logic             left_lt,
    input  logic [KEY_W-1:0] left_entry,
    input  logic [KEY_W-1:0] right_entry,
    output logic [KEY_W-1:0] entry,
    output logic             lt,
    output logic             eq
);

    logic [KEY_W-1:0] entry_reg;
    logic             lt_reg;
    logic             eq_reg;
    logic             in_use;

    assign in_use = CNT_W'(IDX) < count;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lt_reg <= 1'b0;
            eq_reg <= 1'b0;
        end else if (ctrl.cmp) begin
            lt_reg <= in_use && (entry_reg < key);
            eq_reg <= in_use && (entry_reg == key);
        end
    end

    // cells below the key hold; the rest move one place toward the end on insert, toward the start on delete
    always_ff @(posedge aclk) begin
        if (ctrl.ins && !lt_reg) begin
            entry_reg <= left_lt ? key : left_entry;
        end else if (ctrl.del && !lt_reg) begin
            entry_reg <= right_entry;
        end
    end

    assign entry = entry_reg;
    assign lt    = lt_reg;
    assign eq    = eq_reg;

endmodule

// File: sv/sst_reduce.sv
`timescale 1ns / 1ps

module sst_reduce import sst_pkg::*; #(
    parameter int N = 1024
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         en,
    input  logic [N-1:0] hits,
    output logic         any
);

    localparam int GROUPS = (N + GROUP_W - 1) / GROUP_W;

    logic [GROUPS*GROUP_W-1:0] hits_pad;
    logic [GROUPS-1:0]         grp_next;
    logic [GROUPS-1:0]         grp_reg;

    assign hits_pad = (GROUPS*GROUP_W)'(hits);

    for (genvar g = 0; g < GROUPS; g++) begin : g_grp
        assign grp_next[g] = |hits_pad[g*GROUP_W +: GROUP_W];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grp_reg <= '0;
        end else if (en) begin
            grp_reg <= grp_next;
        end
    end

    assign any = |grp_reg;

endmodule

// File: sv/sorted_set_table.sv
`timescale 1ns / 1ps

// channel  dir  tdata fields (low bit up)                   handshake
// s_       in   operation[1:0], value[17:2], pad to 24       s_tvalid/s_tready
// m_       out  present[0], status[2:1], entry_count[13:3]   m_tvalid/m_tready
//
// an item goes through these steps in order: accept, compare in every cell, group or of the
// match flags, then shift the cell row and load the result register
// one item in flight at a time: no new word is accepted until the last one leaves the update step
// reset empties the table at once; stored keys are left as they are
// a stalled result holds the update step until m_tready, no word is dropped

module sorted_set_table import sst_pkg::*; #(
    parameter int CAPACITY   = 1024,
    parameter int VALUE_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // operation, value
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata    // present, status, entry_count
);

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int WIDE_W = (VALUE_BITS > VALUE_W) ? VALUE_BITS : VALUE_W;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CMP  = 4'b0010,
        S_RED  = 4'b0100,
        S_UPD  = 4'b1000
    } state_t;

    state_t                 state_reg, state_next;
    op_t                    op_reg;
    logic [VALUE_BITS-1:0]  key_reg;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   m_valid_reg;
    logic [OUT_DATA_W-1:0]  m_data_reg, m_data_next;

    logic [WIDE_W-1:0]      value_wide;
    logic                   accept;
    logic                   commit;
    logic                   present;
    logic                   full;
    status_t                status;
    cell_ctrl_t             ctrl;

    logic [VALUE_BITS-1:0]  entries [CAPACITY];
    logic [CAPACITY-1:0]    lt_flags;
    logic [CAPACITY-1:0]    eq_flags;

    assign accept     = s_tvalid && s_tready;
    assign s_tready   = state_reg == S_IDLE;
    assign value_wide = WIDE_W'(s_tdata[OP_W +: VALUE_W]);
    assign commit     = (state_reg == S_UPD) && (!m_valid_reg || m_tready);
    assign full       = count_reg == CNT_W'(CAPACITY);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (accept) state_next = S_CMP;
            S_CMP:   state_next = S_RED;
            S_RED:   state_next = S_UPD;
            S_UPD:   if (commit) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        ctrl       = '0;
        ctrl.cmp   = state_reg == S_CMP;
        count_next = count_reg;
        status     = ST_DONE;
        case (op_reg)
            OP_INSERT: begin
                if (full) begin
                    status = ST_FULL;
                end else begin
                    ctrl.ins   = commit;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_DELETE: begin
                if (!present) begin
                    status = ST_MISSING;
                end else begin
                    ctrl.del   = commit;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            default: ;
        endcase
        m_data_next = OUT_DATA_W'({COUNT_OUT_W'(count_next), status, present});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (commit) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg  <= op_t'(s_tdata[OP_W-1:0]);
            key_reg <= value_wide[VALUE_BITS-1:0];
        end
        if (commit) begin
            m_data_reg <= m_data_next;
        end
    end

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic                  left_lt;
        logic [VALUE_BITS-1:0] left_entry;
        logic [VALUE_BITS-1:0] right_entry;

        if (i == 0) begin : g_first
            assign left_lt    = 1'b1;
            assign left_entry = key_reg;
        end else begin : g_mid
            assign left_lt    = lt_flags[i-1];
            assign left_entry = entries[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign right_entry = entries[i];
        end else begin : g_inner
            assign right_entry = entries[i+1];
        end

        sst_cell #(
            .IDX   (i),
            .KEY_W (VALUE_BITS),
            .CNT_W (CNT_W)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl),
            .key         (key_reg),
            .count       (count_reg),
            .left_lt     (left_lt),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .entry       (entries[i]),
            .lt          (lt_flags[i]),
            .eq          (eq_flags[i])
        );
    end

    sst_reduce #(
        .N (CAPACITY)
    ) u_reduce (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (state_reg == S_RED),
        .hits    (eq_flags),
        .any     (present)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == S_CMP)
        else $error("accepted word did not start a compare");

    a_count_only_on_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        !commit |=> count_reg == $past(count_reg))
        else $error("entry count moved outside the update step");

    a_full_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        commit && status == ST_FULL |-> count_next == count_reg && full)
        else $error("insert dropped while the table had room");
`endif

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top import sst_pkg::*; ();

    localparam int          DEPTH      = 1024;
    localparam int          KEY_W      = 16;
    localparam int          CYCLE_CAP  = 400000;
    localparam int          TAIL_WAIT  = 16;
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;  // decoded as a lookup

    typedef struct packed {
        logic                   present;
        status_t                status;
        logic [COUNT_OUT_W-1:0] count;
    } reply_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    // shadow copy of the sorted table
    logic [KEY_W-1:0] shadow_keys [DEPTH];
    int unsigned      shadow_count = 0;

    reply_t pending_replies [$];
    int     error_count  = 0;
    int     cycle_count  = 0;
    int     src_idle_pct = 0;
    int     sink_idle_pct = 0;

    sorted_set_table #(
        .CAPACITY   (DEPTH),
        .VALUE_BITS (KEY_W)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_CAP) begin
            $display("[%0t] timeout after %0d cycles", $time, cycle_count);
            $display("tb_top failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // apply one operation to the shadow table and work out its reply
    function automatic reply_t apply_to_shadow(logic [OP_W-1:0] op, logic [KEY_W-1:0] key);
        reply_t      r;
        int unsigned pos;
        logic        hit;
        pos = 0;
        while (pos < shadow_count && shadow_keys[pos] < key)
            pos++;
        hit = (pos < shadow_count) && (shadow_keys[pos] == key);
        r.present = hit;
        r.status  = ST_DONE;
        if (op == OP_INSERT) begin
            if (shadow_count >= DEPTH) begin
                r.status = ST_FULL;
            end else begin
                for (int i = shadow_count; i > pos; i--)
                    shadow_keys[i] = shadow_keys[i-1];
                shadow_keys[pos] = key;
                shadow_count++;
            end
        end else if (op == OP_DELETE) begin
            if (!hit) begin
                r.status = ST_MISSING;
            end else begin
                for (int i = pos; i + 1 < shadow_count; i++)
                    shadow_keys[i] = shadow_keys[i+1];
                shadow_count--;
            end
        end
        r.count = shadow_count[COUNT_OUT_W-1:0];
        return r;
    endfunction

    always @(posedge aclk) begin : check_replies
        reply_t want;
        reply_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.present = m_tdata[0];
            got.status  = status_t'(m_tdata[2:1]);
            got.count   = m_tdata[13:3];
            if (pending_replies.size() == 0) begin
                $display("[%0t] unexpected word: actual %h", $time, m_tdata);
                error_count++;
            end else begin
                want = pending_replies.pop_front();
                if (got.present !== want.present) begin
                    $display("[%0t] present: expected %0d, actual %0d",
                             $time, want.present, got.present);
                    error_count++;
                end
                if (got.status !== want.status) begin
                    $display("[%0t] status: expected %0d, actual %0d",
                             $time, want.status, got.status);
                    error_count++;
                end
                if (got.count !== want.count) begin
                    $display("[%0t] entry_count: expected %0d, actual %0d",
                             $time, want.count, got.count);
                    error_count++;
                end
            end
        end
    end

    // leaves tvalid high so back-to-back words need no extra nba
    task automatic send_word(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_DATA_W-OP_W-KEY_W){1'b0}}, key, op};
        do @(posedge aclk); while (!s_tready);
        pending_replies.push_back(apply_to_shadow(op, key));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_replies.size() != 0)
            @(posedge aclk);
    endtask

    function automatic logic [OP_W-1:0] pick_op();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 40)
            return OP_INSERT;
        else if (roll < 75)
            return OP_DELETE;
        else if (roll < 92)
            return OP_QUERY;
        return OP_SPARE;
    endfunction

    // half the keys are taken from those stored when any are, so deletes and lookups often hit
    function automatic logic [KEY_W-1:0] pick_key();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 50 && shadow_count > 0)
            return shadow_keys[$urandom_range(shadow_count - 1)];
        else if (roll < 75)
            return KEY_W'($urandom_range(15));
        return KEY_W'($urandom);
    endfunction

    task automatic test_directed();
        send_word(OP_QUERY,  16'h0000);   // empty table
        send_word(OP_DELETE, 16'h0000);
        send_word(OP_INSERT, 16'h0000);
        send_word(OP_INSERT, 16'hFFFF);
        send_word(OP_INSERT, 16'h0000);   // duplicate kept
        send_word(OP_QUERY,  16'h0000);
        send_word(OP_QUERY,  16'hFFFF);
        send_word(OP_SPARE,  16'hFFFF);
        send_word(OP_SPARE,  16'h0005);
        send_word(OP_DELETE, 16'h0000);
        send_word(OP_QUERY,  16'h0000);
        send_word(OP_DELETE, 16'h0000);
        send_word(OP_DELETE, 16'h0000);
        send_word(OP_DELETE, 16'hFFFF);
        send_word(OP_INSERT, 16'h8000);
        send_word(OP_INSERT, 16'h7FFF);
        send_word(OP_INSERT, 16'h5555);
        send_word(OP_INSERT, 16'hAAAA);
        send_word(OP_QUERY,  16'h8000);
        send_word(OP_DELETE, 16'h1234);
        send_word(OP_DELETE, 16'h5555);
    endtask

    task automatic test_random(input int n_words, input logic hold_midway);
        for (int i = 0; i < n_words; i++) begin
            if (hold_midway && i == n_words / 2)
                wait_drained();
            send_word(pick_op(), pick_key());
        end
    endtask

    // filling the table takes most of the words of the run
    task automatic test_full_table();
        while (shadow_count < DEPTH)
            send_word(OP_INSERT, KEY_W'($urandom));
        send_word(OP_INSERT, 16'h0000);
        send_word(OP_INSERT, shadow_keys[DEPTH/2]);
        send_word(OP_QUERY,  shadow_keys[0]);
        send_word(OP_DELETE, shadow_keys[DEPTH-1]);
        send_word(OP_INSERT, 16'hFFFF);
        send_word(OP_INSERT, 16'hFFFF);
        send_word(OP_QUERY,  16'hFFFF);
        send_word(OP_DELETE, KEY_W'($urandom));
        send_word(OP_DELETE, shadow_keys[0]);
        send_word(OP_INSERT, 16'h0000);
        for (int i = 0; i < 40; i++)
            send_word(pick_op(), pick_key());
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        src_idle_pct  = 7;
        sink_idle_pct = 69;
        test_directed();
        test_random(100, 1'b0);

        src_idle_pct  = 69;
        sink_idle_pct = 7;
        test_random(100, 1'b1);

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        test_random(50, 1'b0);
        test_full_table();

        wait_drained();
        repeat (TAIL_WAIT) @(posedge aclk);
        if (error_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

// File: files.f
sv/sst_pkg.sv
sv/sst_cell.sv
sv/sst_reduce.sv
sv/sorted_set_table.sv
tb/tb_top.sv
